// File: rtl/tcd_pkg.sv
// Shared types and decoders for the chunk deframer.
// Used by tcd_front, tcd_fifo, tcd_back and tcp_chunk_deframer.
package tcd_pkg;

	localparam int unsigned HDR_BYTES = 8;
	localparam logic [31:0] MIN_CHUNK = 32'd16;
	localparam logic [31:0] RBUF_RESET = 32'd65535;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_TOO_BIG  = 3'd1,
		ST_TOO_SMALL = 3'd2,
		ST_BAD_MSG  = 3'd3,
		ST_BAD_CHUNK = 3'd4,
		ST_CLOSED   = 3'd5
	} status_t;

	localparam logic [2:0] MK_MSG = 3'd0;
	localparam logic [2:0] MK_ERR = 3'd1;
	localparam logic [2:0] MK_OPN = 3'd2;
	localparam logic [2:0] MK_HEL = 3'd3;
	localparam logic [2:0] MK_ACK = 3'd4;
	localparam logic [2:0] MK_CLO = 3'd5;
	localparam logic [2:0] MK_BAD = 3'd6;

	localparam logic [1:0] CK_FINAL = 2'd0;
	localparam logic [1:0] CK_INTER = 2'd1;
	localparam logic [1:0] CK_ABORT = 2'd2;
	localparam logic [1:0] CK_BAD   = 2'd3;

	// one result word, as it travels from front to back
	typedef struct packed {
		logic [7:0]  out_byte;
		logic [31:0] chunk_offset;
		logic [2:0]  msg_kind;
		logic [1:0]  chunk_kind;
		logic        header_done;
		logic        chunk_last;
		status_t     status;
	} result_t;

	// queue occupancy seen by the front and back
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	// three ASCII bytes, first byte lowest
	function automatic logic [2:0] msg_code(input logic [23:0] name);
		logic [2:0] code;
		unique case (name)
			24'h47534D: code = MK_MSG;
			24'h525245: code = MK_ERR;
			24'h4E504F: code = MK_OPN;
			24'h4C4548: code = MK_HEL;
			24'h4B4341: code = MK_ACK;
			24'h4F4C43: code = MK_CLO;
			default:    code = MK_BAD;
		endcase
		return code;
	endfunction

	function automatic logic [1:0] chunk_code(input logic [7:0] c);
		logic [1:0] code;
		unique case (c)
			8'h46:   code = CK_FINAL;
			8'h43:   code = CK_INTER;
			8'h41:   code = CK_ABORT;
			default: code = CK_BAD;
		endcase
		return code;
	endfunction

endpackage

// File: rtl/tcd_front.sv
// Front end: accepts received bytes, tracks the chunk header and position,
// checks the header and builds one result word per byte. Depends on tcd_pkg.
module tcd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        in_byte,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [31:0]       cfg_data,
	input  tcd_pkg::qstat_t   qstat,
	output logic              push,
	output tcd_pkg::result_t  push_data
);

	logic [31:0] rbuf_size_q;
	logic [31:0] type_q;
	logic [23:0] size_lo_q;
	logic [31:0] chunk_size_q;
	logic [31:0] count_q;
	logic        closed_q;
	logic [2:0]  mk_q;
	logic [1:0]  ck_q;

	logic        in_hdr;
	logic        hdr_end;
	logic [31:0] size_full;
	logic [2:0]  mk_new;
	logic [1:0]  ck_new;
	tcd_pkg::status_t st_new;
	logic [32:0] next_pos;
	logic        body_last;
	logic        accept;

	assign in_ready  = !qstat.full;
	assign cfg_ready = 1'b1;
	assign accept    = in_valid && in_ready;
	assign push      = accept;

	assign in_hdr    = (count_q[31:3] == 29'd0);
	assign hdr_end   = in_hdr && (count_q[2:0] == 3'd7);
	assign size_full = {in_byte, size_lo_q};
	assign mk_new    = tcd_pkg::msg_code(type_q[23:0]);
	assign ck_new    = tcd_pkg::chunk_code(type_q[31:24]);
	assign next_pos  = {1'b0, count_q} + 33'd1;
	assign body_last = (next_pos >= {1'b0, chunk_size_q});

	// checks in priority order
	always_comb begin
		if (size_full > rbuf_size_q) begin
			st_new = tcd_pkg::ST_TOO_BIG;
		end else if (size_full < tcd_pkg::MIN_CHUNK) begin
			st_new = tcd_pkg::ST_TOO_SMALL;
		end else if (mk_new == tcd_pkg::MK_BAD) begin
			st_new = tcd_pkg::ST_BAD_MSG;
		end else if (ck_new == tcd_pkg::CK_BAD) begin
			st_new = tcd_pkg::ST_BAD_CHUNK;
		end else begin
			st_new = tcd_pkg::ST_OK;
		end
	end

	always_comb begin
		push_data = '0;
		if (closed_q) begin
			push_data.status = tcd_pkg::ST_CLOSED;
		end else if (hdr_end) begin
			push_data.out_byte     = in_byte;
			push_data.chunk_offset = count_q;
			push_data.status       = st_new;
			if (st_new == tcd_pkg::ST_OK) begin
				push_data.msg_kind    = mk_new;
				push_data.chunk_kind  = ck_new;
				push_data.header_done = 1'b1;
			end
		end else if (in_hdr) begin
			push_data.out_byte     = in_byte;
			push_data.chunk_offset = count_q;
		end else begin
			push_data.out_byte     = in_byte;
			push_data.chunk_offset = count_q;
			push_data.msg_kind     = mk_q;
			push_data.chunk_kind   = ck_q;
			push_data.chunk_last   = body_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rbuf_size_q <= tcd_pkg::RBUF_RESET;
			count_q     <= '0;
			closed_q    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				rbuf_size_q <= cfg_data;
			end
			if (accept && !closed_q) begin
				if (hdr_end) begin
					if (st_new == tcd_pkg::ST_OK) begin
						count_q <= next_pos[31:0];
					end else begin
						// drop the partial chunk and shut down
						count_q  <= '0;
						closed_q <= 1'b1;
					end
				end else if (!in_hdr && body_last) begin
					count_q <= '0;
				end else begin
					count_q <= next_pos[31:0];
				end
			end
		end
	end

	// header fields; every byte is rewritten before use in the next chunk
	always_ff @(posedge clk) begin
		if (accept && !closed_q && in_hdr) begin
			case (count_q[2:0])
				3'd0:    type_q[7:0]     <= in_byte;
				3'd1:    type_q[15:8]    <= in_byte;
				3'd2:    type_q[23:16]   <= in_byte;
				3'd3:    type_q[31:24]   <= in_byte;
				3'd4:    size_lo_q[7:0]  <= in_byte;
				3'd5:    size_lo_q[15:8] <= in_byte;
				3'd6:    size_lo_q[23:16] <= in_byte;
				default: begin
					chunk_size_q <= size_full;
					mk_q         <= mk_new;
					ck_q         <= ck_new;
				end
			endcase
		end
	end

endmodule

// File: rtl/tcd_fifo.sv
// Two-entry queue of result words between the front and back ends.
// Depends on tcd_pkg.
module tcd_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  tcd_pkg::result_t  push_data,
	input  logic              pop,
	output tcd_pkg::result_t  pop_data,
	output tcd_pkg::qstat_t   qstat
);

	tcd_pkg::result_t mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] level_q;

	assign qstat.full  = (level_q == 2'd2);
	assign qstat.empty = (level_q == 2'd0);
	assign pop_data    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   level_q <= level_q + 2'd1;
				2'b01:   level_q <= level_q - 2'd1;
				default: level_q <= level_q;
			endcase
		end
	end

endmodule

// File: rtl/tcd_back.sv
// Back end: drains the queue into the output register and packs the
// result word onto the master stream. Depends on tcd_pkg.
module tcd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  tcd_pkg::qstat_t   qstat,
	input  tcd_pkg::result_t  pop_data,
	output logic              pop,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [39:0]       m_axis_tdata,
	output logic              m_axis_tlast,
	output logic [8:0]        m_axis_tuser
);

	tcd_pkg::result_t out_q;
	logic             valid_q;

	// refill whenever the register is free or being taken
	assign pop = !qstat.empty && (!valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= pop_data;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = {out_q.chunk_offset, out_q.out_byte};
	assign m_axis_tlast  = out_q.chunk_last;
	assign m_axis_tuser  = {out_q.status, out_q.header_done, out_q.chunk_kind, out_q.msg_kind};

endmodule

// File: rtl/tcp_chunk_deframer.sv
// Chunk deframer top level: joins front end, result queue and back end.
// Depends on tcd_pkg, tcd_front, tcd_fifo and tcd_back.
//
// Usage: received connection bytes enter s_axis one per cycle while ready.
// Each word leaves on m_axis with its offset in the chunk, the message and
// chunk kinds (valid from the eighth header byte), a header-done flag on the
// eighth byte of a good header, a status code, and tlast on the final byte
// of a chunk. A failed header check reports its status on that byte, drops
// the chunk and closes the block: every later word comes out with status
// closed and zero fields until reset.
// cfg_valid/cfg_data write the largest chunk size accepted (65535 after
// reset); write it only while no word is in flight.
// An accepted word is written into the queue, then moved into the output
// register, where it waits on m_axis until the receiver takes it.
// Throughput: one word per cycle unless m_axis stalls. The header checks and
// end-of-chunk compare settle in the front end within the accepting cycle.
// A two-word queue and the output register separate the sides, so input
// is taken while a result waits; s_axis_tready drops only when the queue is
// full under a stalled receiver. Reset clears counters, the closed flag and
// all valids.
module tcp_chunk_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,       // recv_buffer_size
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // [7:0] out_byte, [39:8] chunk_offset
	output logic        m_axis_tlast,   // chunk_last
	output logic [8:0]  m_axis_tuser    // [2:0] msg_kind, [4:3] chunk_kind,
	                                    // [5] header_done, [8:6] status
);

	tcd_pkg::qstat_t  qstat;
	tcd_pkg::result_t push_data;
	tcd_pkg::result_t pop_data;
	logic             push;
	logic             pop;

	tcd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_byte   (s_axis_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.qstat     (qstat),
		.push      (push),
		.push_data (push_data)
	);

	tcd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.qstat     (qstat)
	);

	tcd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.qstat         (qstat),
		.pop_data      (pop_data),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule
